>>> rtl/tgdp_pkg.sv
`default_nettype none
package tgdp_pkg;

  localparam int unsigned DEF_ROW_COUNT = 16;
  localparam int unsigned DEF_COL_COUNT = 16;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // reduce a 4-bit coordinate modulo a grid dimension of at least 3
  function automatic logic [3:0] mod_small(input logic [3:0] v, input int unsigned m);
    logic [3:0] t;
    t = v;
    for (int i = 0; i < 5; i++) begin
      if (32'(t) >= m) begin
        t = t - 4'(m);
      end
    end
    return t;
  endfunction

endpackage
`default_nettype wire

>>> rtl/tgdp_ram.sv
`default_nettype none
module tgdp_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/tgdp_geom.sv
`default_nettype none
module tgdp_geom import tgdp_pkg::*; #(
  parameter int unsigned ROW_COUNT = DEF_ROW_COUNT,
  parameter int unsigned COL_COUNT = DEF_COL_COUNT,
  parameter int unsigned RW = $clog2(ROW_COUNT),
  parameter int unsigned CW = $clog2(COL_COUNT),
  parameter int unsigned DW = $clog2(ROW_COUNT + COL_COUNT - 1)
) (
  input  wire logic [RW-1:0] x_row,
  input  wire logic [CW-1:0] x_col,
  input  wire logic [RW-1:0] dst_row,
  input  wire logic [CW-1:0] dst_col,
  input  wire logic [RW-1:0] a_row,
  input  wire logic [CW-1:0] a_col,
  input  wire logic [RW-1:0] b_row,
  input  wire logic [CW-1:0] b_col,
  output logic      [RW-1:0] nb_row [4],
  output logic      [CW-1:0] nb_col [4],
  output logic      [DW-1:0] nb_dist [4],
  output logic               nb_hit,
  output logic               ab_adj,
  output logic      [1:0]    ab_dir
);

  function automatic logic [RW-1:0] row_dec(input logic [RW-1:0] r);
    return (r == '0) ? RW'(ROW_COUNT - 1) : r - 1'b1;
  endfunction

  function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r);
    return (r == RW'(ROW_COUNT - 1)) ? '0 : r + 1'b1;
  endfunction

  function automatic logic [CW-1:0] col_dec(input logic [CW-1:0] c);
    return (c == '0) ? CW'(COL_COUNT - 1) : c - 1'b1;
  endfunction

  function automatic logic [CW-1:0] col_inc(input logic [CW-1:0] c);
    return (c == CW'(COL_COUNT - 1)) ? '0 : c + 1'b1;
  endfunction

  logic [RW-1:0] rdiff [4];
  logic [CW-1:0] cdiff [4];

  always_comb begin
    nb_row[0] = row_dec(x_row);
    nb_col[0] = x_col;
    nb_row[1] = row_inc(x_row);
    nb_col[1] = x_col;
    nb_row[2] = x_row;
    nb_col[2] = col_dec(x_col);
    nb_row[3] = x_row;
    nb_col[3] = col_inc(x_col);
    nb_hit = 1'b0;
    for (int k = 0; k < 4; k++) begin
      rdiff[k] = (nb_row[k] > dst_row) ? nb_row[k] - dst_row : dst_row - nb_row[k];
      cdiff[k] = (nb_col[k] > dst_col) ? nb_col[k] - dst_col : dst_col - nb_col[k];
      nb_dist[k] = DW'(rdiff[k]) + DW'(cdiff[k]);
      if (nb_row[k] == dst_row && nb_col[k] == dst_col) begin
        nb_hit = 1'b1;
      end
    end
  end

  always_comb begin
    ab_adj = 1'b1;
    ab_dir = DIR_UP;
    priority if (a_col == b_col && b_row == row_dec(a_row)) begin
      ab_dir = DIR_UP;
    end else if (a_col == b_col && b_row == row_inc(a_row)) begin
      ab_dir = DIR_DOWN;
    end else if (a_row == b_row && b_col == col_dec(a_col)) begin
      ab_dir = DIR_LEFT;
    end else if (a_row == b_row && b_col == col_inc(a_col)) begin
      ab_dir = DIR_RIGHT;
    end else begin
      ab_adj = 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/torus_grid_greedy_dfs_path_unit.sv
`default_nettype none
// Greedy depth-first path search on a wrapping grid. After reset the unit sweeps all
// 2**(clog2(ROW_COUNT)+clog2(COL_COUNT)) entries (256 by default) of its occupancy and
// visited maps, one entry a cycle, with in_stall high. A cell write or an unused kind
// goes straight to the done state, a move read passes a read state first. A search is
// run by one sequencer around a shared neighbor/adjacency unit: each popped cell goes
// through pop, stack read, backtrack of the path chain and append, then one select and
// check per neighbor examined; the move write-back follows, and the visited map is then
// swept like at reset. One item is in work at a time; the result register lets the next
// item be taken while a result still waits.
module torus_grid_greedy_dfs_path_unit import tgdp_pkg::*; #(
  parameter int unsigned ROW_COUNT = DEF_ROW_COUNT,
  parameter int unsigned COL_COUNT = DEF_COL_COUNT
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_kind,
  input  wire logic [3:0] in_cell_row,
  input  wire logic [3:0] in_cell_col,
  input  wire logic       in_cell_free,
  input  wire logic [3:0] in_dest_row,
  input  wire logic [3:0] in_dest_col,
  input  wire logic       in_wander,
  input  wire logic [7:0] in_move_index,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_found,
  output logic [8:0]      out_move_count,
  output logic [1:0]      out_direction
);

  localparam int unsigned RW    = $clog2(ROW_COUNT);
  localparam int unsigned CW    = $clog2(COL_COUNT);
  localparam int unsigned AW    = RW + CW;
  localparam int unsigned DW    = $clog2(ROW_COUNT + COL_COUNT - 1);
  localparam int unsigned CELLS = ROW_COUNT * COL_COUNT;
  localparam int unsigned SAW   = $clog2(CELLS);
  localparam int unsigned CAW   = $clog2(CELLS + 1);
  localparam int unsigned SPW   = $clog2(CELLS + 1);
  localparam int unsigned LW    = $clog2(CELLS + 2);

  localparam logic [4:0] S_RCLR   = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_READ   = 5'd2;
  localparam logic [4:0] S_START  = 5'd3;
  localparam logic [4:0] S_POP    = 5'd4;
  localparam logic [4:0] S_POPW   = 5'd5;
  localparam logic [4:0] S_BTREQ  = 5'd6;
  localparam logic [4:0] S_BTCHK  = 5'd7;
  localparam logic [4:0] S_APPEND = 5'd8;
  localparam logic [4:0] S_HIT    = 5'd9;
  localparam logic [4:0] S_SEL    = 5'd10;
  localparam logic [4:0] S_CHK    = 5'd11;
  localparam logic [4:0] S_FIN    = 5'd12;
  localparam logic [4:0] S_MV0    = 5'd13;
  localparam logic [4:0] S_MV1    = 5'd14;
  localparam logic [4:0] S_MVS    = 5'd15;
  localparam logic [4:0] S_VCLR   = 5'd16;
  localparam logic [4:0] S_DONE   = 5'd17;

  logic [4:0]     state_r, state_nxt;
  logic [AW-1:0]  clr_idx_r, clr_idx_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [LW-1:0]  clen_r, clen_nxt;
  logic [3:0]     mask_r, mask_nxt;
  logic [SPW-1:0] stored_r, stored_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic [RW-1:0]  cur_row_r, cur_row_nxt, dst_row_r, dst_row_nxt;
  logic [CW-1:0]  cur_col_r, cur_col_nxt, dst_col_r, dst_col_nxt;
  logic [RW-1:0]  last_row_r, last_row_nxt, prev_row_r, prev_row_nxt;
  logic [CW-1:0]  last_col_r, last_col_nxt, prev_col_r, prev_col_nxt;
  logic           wander_r, wander_nxt;
  logic [1:0]     sel_r, sel_nxt;
  logic [SPW-1:0] idx_r, idx_nxt, cnt_r, cnt_nxt;
  logic           res_found_r, res_found_nxt;
  logic [1:0]     res_dir_r, res_dir_nxt;
  logic           out_found_r, out_found_nxt;
  logic [8:0]     out_count_r, out_count_nxt;
  logic [1:0]     out_dir_r, out_dir_nxt;

  logic          fm_we, fm_wdata, fm_rdata;
  logic [AW-1:0] fm_waddr, fm_raddr;
  logic          vm_we, vm_wdata, vm_rdata;
  logic [AW-1:0] vm_waddr, vm_raddr;
  logic           st_we;
  logic [SAW-1:0] st_waddr, st_raddr;
  logic [AW-1:0]  st_wdata, st_rdata;
  logic           ch_we;
  logic [CAW-1:0] ch_waddr, ch_raddr;
  logic [AW-1:0]  ch_wdata, ch_rdata;
  logic           mv_we;
  logic [SAW-1:0] mv_waddr, mv_raddr;
  logic [1:0]     mv_wdata, mv_rdata;

  logic [RW-1:0] nb_row [4];
  logic [CW-1:0] nb_col [4];
  logic [DW-1:0] nb_dist [4];
  logic          nb_hit, ab_adj;
  logic [1:0]    ab_dir;
  logic [RW-1:0] a_row, b_row;
  logic [CW-1:0] a_col, b_col;

  logic          have;
  logic [1:0]    pick;
  logic [DW-1:0] best;
  logic          accept, success;
  logic [SPW-1:0] count;

  tgdp_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_free (
    .clk(clk), .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
    .raddr(fm_raddr), .rdata(fm_rdata)
  );
  tgdp_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_visit (
    .clk(clk), .we(vm_we), .waddr(vm_waddr), .wdata(vm_wdata),
    .raddr(vm_raddr), .rdata(vm_rdata)
  );
  tgdp_ram #(.WIDTH(AW), .DEPTH(CELLS)) u_stack (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );
  tgdp_ram #(.WIDTH(AW), .DEPTH(CELLS + 1)) u_chain (
    .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
    .raddr(ch_raddr), .rdata(ch_rdata)
  );
  tgdp_ram #(.WIDTH(2), .DEPTH(CELLS)) u_moves (
    .clk(clk), .we(mv_we), .waddr(mv_waddr), .wdata(mv_wdata),
    .raddr(mv_raddr), .rdata(mv_rdata)
  );

  tgdp_geom #(.ROW_COUNT(ROW_COUNT), .COL_COUNT(COL_COUNT)) u_geom (
    .x_row(cur_row_r), .x_col(cur_col_r),
    .dst_row(dst_row_r), .dst_col(dst_col_r),
    .a_row(a_row), .a_col(a_col), .b_row(b_row), .b_col(b_col),
    .nb_row(nb_row), .nb_col(nb_col), .nb_dist(nb_dist),
    .nb_hit(nb_hit), .ab_adj(ab_adj), .ab_dir(ab_dir)
  );

  assign in_stall       = (state_r != S_IDLE);
  assign accept         = in_valid && !in_stall;
  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_move_count = out_count_r;
  assign out_direction  = out_dir_r;

  assign success = (last_row_r == dst_row_r) && (last_col_r == dst_col_r);

  // largest distance first, lower neighbor order on ties
  always_comb begin
    have = 1'b0;
    pick = DIR_UP;
    best = '0;
    for (int k = 0; k < 4; k++) begin
      if (!mask_r[k] && (!have || nb_dist[k] > best)) begin
        have = 1'b1;
        pick = 2'(k);
        best = nb_dist[k];
      end
    end
  end

  always_comb begin
    if (state_r == S_BTCHK) begin
      a_row = ch_rdata[AW-1:CW];
      a_col = ch_rdata[CW-1:0];
      b_row = cur_row_r;
      b_col = cur_col_r;
    end else begin
      a_row = prev_row_r;
      a_col = prev_col_r;
      b_row = ch_rdata[AW-1:CW];
      b_col = ch_rdata[CW-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    sp_nxt        = sp_r;
    clen_nxt      = clen_r;
    mask_nxt      = mask_r;
    stored_nxt    = stored_r;
    out_valid_nxt = out_valid_r && out_stall;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    dst_row_nxt   = dst_row_r;
    dst_col_nxt   = dst_col_r;
    last_row_nxt  = last_row_r;
    last_col_nxt  = last_col_r;
    prev_row_nxt  = prev_row_r;
    prev_col_nxt  = prev_col_r;
    wander_nxt    = wander_r;
    sel_nxt       = sel_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    res_found_nxt = res_found_r;
    res_dir_nxt   = res_dir_r;
    out_found_nxt = out_found_r;
    out_count_nxt = out_count_r;
    out_dir_nxt   = out_dir_r;
    count         = SPW'(clen_r - 1'b1);

    fm_we = 1'b0; fm_waddr = clr_idx_r; fm_wdata = 1'b0; fm_raddr = '0;
    vm_we = 1'b0; vm_waddr = clr_idx_r; vm_wdata = 1'b0; vm_raddr = '0;
    st_we = 1'b0; st_waddr = SAW'(sp_r); st_wdata = {cur_row_r, cur_col_r};
    st_raddr = SAW'(sp_r - 1'b1);
    ch_we = 1'b0; ch_waddr = CAW'(clen_r); ch_wdata = {cur_row_r, cur_col_r};
    ch_raddr = CAW'(clen_r - 1'b1);
    mv_we = 1'b0; mv_waddr = SAW'(idx_r); mv_wdata = ab_adj ? ab_dir : DIR_UP;
    mv_raddr = SAW'(in_move_index);

    unique case (state_r)
      S_RCLR: begin
        fm_we = 1'b1;
        vm_we = 1'b1;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (&clr_idx_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        res_found_nxt = 1'b0;
        res_dir_nxt   = DIR_UP;
        if (accept) begin
          unique case (in_kind)
            KIND_WRITE: begin
              fm_we     = 1'b1;
              fm_waddr  = {RW'(mod_small(in_cell_row, ROW_COUNT)),
                           CW'(mod_small(in_cell_col, COL_COUNT))};
              fm_wdata  = in_cell_free;
              state_nxt = S_DONE;
            end
            KIND_SEARCH: begin
              cur_row_nxt = RW'(mod_small(in_cell_row, ROW_COUNT));
              cur_col_nxt = CW'(mod_small(in_cell_col, COL_COUNT));
              dst_row_nxt = RW'(mod_small(in_dest_row, ROW_COUNT));
              dst_col_nxt = CW'(mod_small(in_dest_col, COL_COUNT));
              wander_nxt  = in_wander;
              state_nxt   = S_START;
            end
            KIND_READ: begin
              res_found_nxt = (32'(in_move_index) < 32'(stored_r));
              state_nxt     = S_READ;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        res_dir_nxt = res_found_r ? mv_rdata : DIR_UP;
        state_nxt   = S_DONE;
      end
      S_START: begin
        st_we     = 1'b1;
        st_waddr  = '0;
        sp_nxt    = SPW'(1);
        clen_nxt  = '0;
        state_nxt = S_POP;
      end
      S_POP: begin
        if (sp_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          sp_nxt    = sp_r - 1'b1;
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        cur_row_nxt = st_rdata[AW-1:CW];
        cur_col_nxt = st_rdata[CW-1:0];
        state_nxt   = S_BTREQ;
      end
      S_BTREQ: begin
        state_nxt = (clen_r == '0) ? S_APPEND : S_BTCHK;
      end
      S_BTCHK: begin
        if (ab_adj) begin
          state_nxt = S_APPEND;
        end else begin
          clen_nxt = clen_r - 1'b1;
          ch_raddr = CAW'(clen_r - 2'd2);
          if (clen_r == LW'(1)) begin
            state_nxt = S_APPEND;
          end
        end
      end
      S_APPEND: begin
        if (32'(clen_r) < CELLS + 1) begin
          ch_we        = 1'b1;
          clen_nxt     = clen_r + 1'b1;
          last_row_nxt = cur_row_r;
          last_col_nxt = cur_col_r;
        end
        mask_nxt  = '0;
        state_nxt = nb_hit ? S_HIT : S_SEL;
      end
      S_HIT: begin
        if (32'(clen_r) < CELLS + 1) begin
          ch_we        = 1'b1;
          ch_wdata     = {dst_row_r, dst_col_r};
          clen_nxt     = clen_r + 1'b1;
          last_row_nxt = dst_row_r;
          last_col_nxt = dst_col_r;
        end
        state_nxt = S_FIN;
      end
      S_SEL: begin
        if (!have) begin
          state_nxt = S_POP;
        end else begin
          fm_raddr       = {nb_row[pick], nb_col[pick]};
          vm_raddr       = {nb_row[pick], nb_col[pick]};
          sel_nxt        = pick;
          mask_nxt[pick] = 1'b1;
          state_nxt      = S_CHK;
        end
      end
      S_CHK: begin
        if (fm_rdata && !vm_rdata && 32'(sp_r) < CELLS) begin
          st_we    = 1'b1;
          st_wdata = {nb_row[sel_r], nb_col[sel_r]};
          vm_we    = 1'b1;
          vm_waddr = {nb_row[sel_r], nb_col[sel_r]};
          vm_wdata = 1'b1;
          sp_nxt   = sp_r + 1'b1;
        end
        state_nxt = S_SEL;
      end
      S_FIN: begin
        clr_idx_nxt = '0;
        if (!success && !wander_r) begin
          stored_nxt    = '0;
          res_found_nxt = 1'b0;
          state_nxt     = S_VCLR;
        end else begin
          if (!success && count > SPW'(1)) begin
            count = SPW'(1);
          end
          res_found_nxt = 1'b1;
          stored_nxt    = count;
          cnt_nxt       = count;
          state_nxt     = (count == '0) ? S_VCLR : S_MV0;
        end
      end
      S_MV0: begin
        ch_raddr  = '0;
        state_nxt = S_MV1;
      end
      S_MV1: begin
        prev_row_nxt = ch_rdata[AW-1:CW];
        prev_col_nxt = ch_rdata[CW-1:0];
        ch_raddr     = CAW'(1);
        idx_nxt      = '0;
        state_nxt    = S_MVS;
      end
      S_MVS: begin
        mv_we        = 1'b1;
        prev_row_nxt = ch_rdata[AW-1:CW];
        prev_col_nxt = ch_rdata[CW-1:0];
        idx_nxt      = idx_r + 1'b1;
        ch_raddr     = CAW'(idx_r + 2'd2);
        if (idx_r + 1'b1 == cnt_r) begin
          state_nxt = S_VCLR;
        end
      end
      S_VCLR: begin
        vm_we       = 1'b1;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (&clr_idx_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_count_nxt = 9'(stored_r);
          out_dir_nxt   = res_dir_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RCLR;
      clr_idx_r   <= '0;
      sp_r        <= '0;
      clen_r      <= '0;
      mask_r      <= '0;
      stored_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      sp_r        <= sp_nxt;
      clen_r      <= clen_nxt;
      mask_r      <= mask_nxt;
      stored_r    <= stored_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_row_r   <= cur_row_nxt;
    cur_col_r   <= cur_col_nxt;
    dst_row_r   <= dst_row_nxt;
    dst_col_r   <= dst_col_nxt;
    last_row_r  <= last_row_nxt;
    last_col_r  <= last_col_nxt;
    prev_row_r  <= prev_row_nxt;
    prev_col_r  <= prev_col_nxt;
    wander_r    <= wander_nxt;
    sel_r       <= sel_nxt;
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
    res_found_r <= res_found_nxt;
    res_dir_r   <= res_dir_nxt;
    out_found_r <= out_found_nxt;
    out_count_r <= out_count_nxt;
    out_dir_r   <= out_dir_nxt;
  end

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sp_r) <= CELLS)
    else $error("search stack overflow");

  a_chain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(clen_r) <= CELLS + 1)
    else $error("path chain overflow");

  a_mv_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MVS |-> (cnt_r != '0) && (idx_r < cnt_r))
    else $error("move write-back index out of range");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("item result raised outside done state");

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import tgdp_pkg::*;

  localparam int NR = DEF_ROW_COUNT;
  localparam int NC = DEF_COL_COUNT;
  localparam int NCELL = NR * NC;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic       found;
    logic [8:0] move_count;
    logic [1:0] direction;
  } path_result_t;

  class path_scoreboard;
    bit           free_cells[NCELL];
    bit           seen[NCELL];
    int           dfs_stack[NCELL];
    int           chain[NCELL + 1];
    logic [1:0]   moves[NCELL];
    int           n_moves;
    path_result_t pending[$];
    int           errors;

    function int dir_between(int a, int b);
      int ra, ca, rb, cb;
      ra = a / NC; ca = a % NC; rb = b / NC; cb = b % NC;
      if (ca == cb && rb == (ra + NR - 1) % NR) return DIR_UP;
      if (ca == cb && rb == (ra + 1) % NR) return DIR_DOWN;
      if (ra == rb && cb == (ca + NC - 1) % NC) return DIR_LEFT;
      if (ra == rb && cb == (ca + 1) % NC) return DIR_RIGHT;
      return 4;
    endfunction

    function int step_cell(int c, int d);
      int r, k;
      r = c / NC; k = c % NC;
      case (d)
        DIR_UP:   r = (r + NR - 1) % NR;
        DIR_DOWN: r = (r + 1) % NR;
        DIR_LEFT: k = (k + NC - 1) % NC;
        default:  k = (k + 1) % NC;
      endcase
      return r * NC + k;
    endfunction

    function int manhattan(int a, int b);
      int dr, dc;
      dr = a / NC - b / NC; dc = a % NC - b % NC;
      if (dr < 0) dr = -dr;
      if (dc < 0) dc = -dc;
      return dr + dc;
    endfunction

    function bit walk(int start, int dest, bit wander);
      int sp, clen, cur, cnt, v, j, dir;
      int nb[4];
      int d[4];
      int s[4];
      bit hit, ok;
      sp = 0; clen = 0;
      dfs_stack[sp] = start;
      sp = sp + 1;
      while (sp > 0) begin
        sp = sp - 1;
        cur = dfs_stack[sp];
        hit = 0;
        while (clen > 0 && dir_between(chain[clen-1], cur) > 3) clen--;
        if (clen < NCELL + 1) begin
          chain[clen] = cur;
          clen = clen + 1;
        end
        for (int k = 0; k < 4; k++) nb[k] = step_cell(cur, k);
        for (int k = 0; k < 4; k++)
          if (!hit && nb[k] == dest) begin
            if (clen < NCELL + 1) begin
              chain[clen] = dest;
              clen = clen + 1;
            end
            hit = 1;
          end
        if (hit) break;
        for (int k = 0; k < 4; k++) begin
          d[k] = manhattan(nb[k], dest);
          s[k] = d[k];
        end
        for (int i = 1; i < 4; i++) begin
          v = s[i]; j = i;
          while (j > 0 && s[j-1] > v) begin
            s[j] = s[j-1];
            j--;
          end
          s[j] = v;
        end
        for (int i = 3; i >= 0; i--)
          for (int k = 0; k < 4; k++)
            if (d[k] == s[i] && free_cells[nb[k]] && !seen[nb[k]] && sp < NCELL) begin
              dfs_stack[sp] = nb[k];
              sp = sp + 1;
              seen[nb[k]] = 1;
            end
      end
      foreach (seen[i]) seen[i] = 0;
      ok = (chain[clen-1] == dest);
      if (!ok && !wander) begin
        n_moves = 0;
        return 0;
      end
      cnt = clen - 1;
      if (!ok && cnt > 1) cnt = 1;
      for (int i = 0; i < cnt; i++) begin
        dir = dir_between(chain[i], chain[i+1]);
        moves[i] = (dir > 3) ? 2'd0 : 2'(dir);
      end
      n_moves = cnt;
      return 1;
    endfunction

    function void note_item(logic [1:0] kind, logic [3:0] r, logic [3:0] c, logic fr,
                            logic [3:0] dr, logic [3:0] dc, logic wd, logic [7:0] idx);
      path_result_t e;
      e = '0;
      case (kind)
        KIND_WRITE: free_cells[(r % NR) * NC + (c % NC)] = fr;
        KIND_SEARCH:
          e.found = walk((r % NR) * NC + (c % NC), (dr % NR) * NC + (dc % NC), wd);
        KIND_READ:
          if (idx < n_moves) begin
            e.found = 1;
            e.direction = moves[idx];
          end
        default: ;
      endcase
      e.move_count = 9'(n_moves);
      pending.push_back(e);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(path_result_t got);
      path_result_t e;
      if (pending.size() == 0) begin
        report("result with none expected");
        return;
      end
      e = pending.pop_front();
      if (got.found !== e.found)
        report($sformatf("found %0b exp %0b", got.found, e.found));
      if (got.move_count !== e.move_count)
        report($sformatf("move_count %0d exp %0d", got.move_count, e.move_count));
      if (got.direction !== e.direction)
        report($sformatf("direction %0d exp %0d", got.direction, e.direction));
    endtask
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_kind;
  logic [3:0] in_cell_row, in_cell_col, in_dest_row, in_dest_col;
  logic in_cell_free, in_wander;
  logic [7:0] in_move_index;
  logic out_valid, out_stall, out_found;
  logic [8:0] out_move_count;
  logic [1:0] out_direction;

  path_scoreboard sb = new();
  bit hold_off = 0;

  torus_grid_greedy_dfs_path_unit i_dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAIL torus_grid_greedy_dfs_path_unit");
    $finish;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send(logic [1:0] kind, logic [3:0] r, logic [3:0] c, logic fr,
                      logic [3:0] dr, logic [3:0] dc, logic wd, logic [7:0] idx);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1; in_kind <= kind; in_cell_row <= r; in_cell_col <= c;
    in_cell_free <= fr; in_dest_row <= dr; in_dest_col <= dc; in_wander <= wd;
    in_move_index <= idx;
    do @(posedge clk); while (in_stall);
    sb.note_item(kind, r, c, fr, dr, dc, wd, idx);
  endtask

  task automatic put_cell(int r, int c, bit fr);
    send(KIND_WRITE, 4'(r), 4'(c), fr, 4'($urandom), 4'($urandom), 1'($urandom),
         8'($urandom));
  endtask

  task automatic search(int r, int c, int dr, int dc, bit wd);
    send(KIND_SEARCH, 4'(r), 4'(c), 1'($urandom), 4'(dr), 4'(dc), wd, 8'($urandom));
  endtask

  task automatic read_move(int idx);
    send(KIND_READ, 4'($urandom), 4'($urandom), 1'($urandom), 4'($urandom),
         4'($urandom), 1'($urandom), 8'(idx));
  endtask

  task automatic read_all();
    for (int i = 0; i < sb.n_moves && i < 6; i++) read_move(i);
    read_move(sb.n_moves);
  endtask

  task automatic random_item();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) put_cell($urandom, $urandom, $urandom_range(0, 9) < 7);
    else if (p < 65) search($urandom, $urandom, $urandom, $urandom, 1'($urandom));
    else if (p < 97) read_move($urandom_range(0, sb.n_moves + 2));
    else send(KIND_UNUSED, 4'($urandom), 4'($urandom), 1'($urandom), 4'($urandom),
              4'($urandom), 1'($urandom), 8'($urandom));
  endtask

  always @(posedge clk) begin
    if (!rst_n || hold_off) out_stall <= 1;
    else out_stall <= ($urandom_range(0, 99) < 25) ? 1'b1 :
                      ($urandom_range(0, 99) < 3);
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_found, out_move_count, out_direction});
  end

  initial begin
    in_valid = 0; in_kind = KIND_WRITE; in_cell_row = 0; in_cell_col = 0;
    in_cell_free = 0; in_dest_row = 0; in_dest_col = 0; in_wander = 0;
    in_move_index = 0; rst_n = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // blocked grid: no move, wander and not
    search(0, 0, 15, 15, 0);
    search(15, 15, 0, 0, 1);
    search(3, 3, 3, 3, 0);
    read_move(0);
    // open row across the wrap edge
    for (int c = 0; c < 16; c++) put_cell(7, c, 1);
    search(7, 14, 7, 2, 0);
    read_all();
    search(7, 5, 7, 5, 1);
    read_move(255);
    send(KIND_UNUSED, 4'hf, 4'hf, 1, 4'hf, 4'hf, 1, 8'hff);
    search(7, 0, 0, 0, 1);
    read_move(0);

    // free the first three cells of row 0, pressure phase with receiver held off
    fork
      begin
        for (int r = 0; r < 16; r++)
          for (int c = 0; c < 16; c++)
            if (r == 0 && c < 3) put_cell(r, c, 1);
      end
      begin
        hold_off = 1;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
    join

    for (int n = 0; n < 380; n++) begin
      if (n % 150 == 0)
        for (int k = 0; k < 40; k++) put_cell($urandom, $urandom, $urandom_range(0, 9) < 7);
      if (n % 40 == 0) begin
        search($urandom, $urandom, $urandom, $urandom, 1'($urandom));
        read_all();
      end else random_item();
    end
    in_valid <= 0;

    begin : drain
      while (sb.pending.size() != 0) @(posedge clk);
      repeat (50) @(posedge clk);
    end
    if (sb.errors == 0) $display("PASS torus_grid_greedy_dfs_path_unit");
    else $display("FAIL torus_grid_greedy_dfs_path_unit");
    $finish;
  end
endmodule
